/* design/tbb_pkg.sv */
// Package: shared types, codes, constants and saturation helper for the text bounding box.
`default_nettype none
package tbb_pkg;

	localparam int GLYPH_COUNT_DEF = 128;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_CR = 8'd13;

	localparam logic [7:0] FIRST_CHAR_RST = 8'd32;
	localparam logic [7:0] LAST_CHAR_RST = 8'd126;
	localparam logic [7:0] LINE_ADV_RST = 8'd0;

	localparam logic signed [33:0] S32_MAX_W = 34'sh0_7FFF_FFFF;
	localparam logic signed [33:0] S32_MIN_W = 34'sh3_8000_0000;

	typedef enum logic [1:0] {
		REG_FIRST_CHAR = 2'd0,
		REG_LAST_CHAR  = 2'd1,
		REG_LINE_ADV   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_BEGIN = 2'd1,
		FUNC_CHAR  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		OP_SKIP,
		OP_BEGIN,
		OP_NEWLINE,
		OP_GLYPH
	} op_t;

	typedef struct packed {
		logic [7:0] first_char;
		logic [7:0] last_char;
		logic [7:0] line_advance;
	} cfg_t;

	typedef struct packed {
		logic [7:0]        w;
		logic [7:0]        h;
		logic signed [7:0] xo;
		logic signed [7:0] yo;
		logic [7:0]        xa;
	} glyph_t;

	typedef struct packed {
		op_t                op;
		logic               emit;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] min_x;
		logic signed [31:0] min_y;
		logic signed [31:0] max_x;
		logic signed [31:0] max_y;
	} box_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX_W) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < S32_MIN_W) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/tbb_text_if.sv */
// Interface: input item channel carrying load, begin and character items.
`default_nettype none
interface tbb_text_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [6:0]         glyph_index;
	logic [7:0]         glyph_width;
	logic [7:0]         glyph_height;
	logic signed [7:0]  offset_x;
	logic signed [7:0]  offset_y;
	logic [7:0]         advance_x;
	logic signed [15:0] origin_x;
	logic signed [15:0] origin_y;
	logic [7:0]         char_code;
	logic               end_of_text;

	modport source (
		output valid, func, glyph_index, glyph_width, glyph_height, offset_x, offset_y,
			advance_x, origin_x, origin_y, char_code, end_of_text,
		input  ready
	);
	modport sink (
		input  valid, func, glyph_index, glyph_width, glyph_height, offset_x, offset_y,
			advance_x, origin_x, origin_y, char_code, end_of_text,
		output ready
	);
endinterface
`default_nettype wire

/* design/tbb_bbox_if.sv */
// Interface: result item channel carrying the measured box.
`default_nettype none
interface tbb_bbox_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] left_x;
	logic signed [31:0] top_y;
	logic [30:0]        box_width;
	logic [30:0]        box_height;

	modport source (
		output valid, left_x, top_y, box_width, box_height,
		input  ready
	);
	modport sink (
		input  valid, left_x, top_y, box_width, box_height,
		output ready
	);
endinterface
`default_nettype wire

/* design/tbb_regs.sv */
// Configuration register file behind the APB-style port.
`default_nettype none
module tbb_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tbb_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [tbb_pkg::APB_DATA_W-1:0] pwdata,
	output      logic [tbb_pkg::APB_DATA_W-1:0] prdata,
	output      logic                          pready,
	output      tbb_pkg::cfg_t                 cfg
);
	import tbb_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_char <= FIRST_CHAR_RST;
			cfg_q.last_char <= LAST_CHAR_RST;
			cfg_q.line_advance <= LINE_ADV_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_FIRST_CHAR: cfg_q.first_char <= pwdata[7:0];
				REG_LAST_CHAR:  cfg_q.last_char <= pwdata[7:0];
				REG_LINE_ADV:   cfg_q.line_advance <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_FIRST_CHAR: prdata = {24'd0, cfg_q.first_char};
			REG_LAST_CHAR:  prdata = {24'd0, cfg_q.last_char};
			REG_LINE_ADV:   prdata = {24'd0, cfg_q.line_advance};
			default:        prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

/* design/tbb_glyph_table.sv */
// Glyph metrics memory: one write port, one registered read port.
`default_nettype none
module tbb_glyph_table #(
	parameter  int GLYPH_COUNT = tbb_pkg::GLYPH_COUNT_DEF,
	localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire tbb_pkg::glyph_t  wr_data,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output      tbb_pkg::glyph_t  rd_data
);
	import tbb_pkg::*;

	glyph_t mem [GLYPH_COUNT];
	glyph_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
endmodule
`default_nettype wire

/* design/tbb_cursor.sv */
// Cursor and running box: applies one begin or character command per cycle in which step is high.
`default_nettype none
module tbb_cursor (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire tbb_pkg::cmd_t   cmd,
	input  wire tbb_pkg::glyph_t glyph,
	input  wire logic [7:0]      line_advance,
	output      tbb_pkg::box_t   box_next
);
	import tbb_pkg::*;

	logic signed [15:0] start_x_q;
	logic signed [31:0] cursor_x_q;
	logic signed [31:0] cursor_y_q;
	box_t               box_q;

	logic signed [31:0] cursor_x_d;
	logic signed [31:0] cursor_y_d;
	logic signed [15:0] start_x_d;
	box_t               box_d;
	logic signed [31:0] x0;
	logic signed [31:0] y0;
	logic signed [31:0] x1;
	logic signed [31:0] y1;

	always_comb begin
		x0 = sat32({{2{cursor_x_q[31]}}, cursor_x_q} + {{26{glyph.xo[7]}}, glyph.xo});
		y0 = sat32({{2{cursor_y_q[31]}}, cursor_y_q} + {{26{glyph.yo[7]}}, glyph.yo});
		x1 = sat32({{2{x0[31]}}, x0} + {26'd0, glyph.w});
		y1 = sat32({{2{y0[31]}}, y0} + {26'd0, glyph.h});

		start_x_d = start_x_q;
		cursor_x_d = cursor_x_q;
		cursor_y_d = cursor_y_q;
		box_d = box_q;
		case (cmd.op)
			OP_BEGIN: begin
				start_x_d = cmd.origin_x;
				cursor_x_d = 32'(cmd.origin_x);
				cursor_y_d = 32'(cmd.origin_y);
				box_d.min_x = 32'(cmd.origin_x);
				box_d.max_x = 32'(cmd.origin_x);
				box_d.min_y = 32'(cmd.origin_y);
				box_d.max_y = 32'(cmd.origin_y);
			end
			OP_NEWLINE: begin
				cursor_x_d = 32'(start_x_q);
				cursor_y_d = sat32({{2{cursor_y_q[31]}}, cursor_y_q} + {26'd0, line_advance});
			end
			OP_GLYPH: begin
				// grow the box by the glyph rectangle, then advance the pen
				if (x0 < box_q.min_x) box_d.min_x = x0;
				if (y0 < box_q.min_y) box_d.min_y = y0;
				if (x1 > box_q.max_x) box_d.max_x = x1;
				if (y1 > box_q.max_y) box_d.max_y = y1;
				cursor_x_d = sat32({{2{cursor_x_q[31]}}, cursor_x_q} + {26'd0, glyph.xa});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			box_q <= '0;
		end else if (step) begin
			start_x_q <= start_x_d;
			cursor_x_q <= cursor_x_d;
			cursor_y_q <= cursor_y_d;
			box_q <= box_d;
		end
	end

	assign box_next = box_d;
endmodule
`default_nettype wire

/* design/tbb_result.sv */
// Result register: holds the finished box and forms width and height.
`default_nettype none
module tbb_result (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire tbb_pkg::box_t box,
	output      logic          busy,
	tbb_bbox_if.source         bbox
);
	import tbb_pkg::*;

	logic        valid_q;
	box_t        box_q;
	logic [32:0] dx;
	logic [32:0] dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (bbox.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			box_q <= box;
		end
	end

	// 33-bit spans; clamp negative to zero and large to the 31-bit max
	assign dx = {box_q.max_x[31], box_q.max_x} - {box_q.min_x[31], box_q.min_x};
	assign dy = {box_q.max_y[31], box_q.max_y} - {box_q.min_y[31], box_q.min_y};

	always_comb begin
		if (dx[32]) bbox.box_width = '0;
		else if (dx[31]) bbox.box_width = '1;
		else bbox.box_width = dx[30:0];
		if (dy[32]) bbox.box_height = '0;
		else if (dy[31]) bbox.box_height = '1;
		else bbox.box_height = dy[30:0];
	end

	assign bbox.valid = valid_q;
	assign bbox.left_x = box_q.min_x;
	assign bbox.top_y = box_q.min_y;
	assign busy = valid_q && !bbox.ready;
endmodule
`default_nettype wire

/* design/text_bounding_box.sv */
// Top level: text bounding box measurement with glyph table and APB configuration.
// Throughput: one item per cycle while stage 1 is not held by a busy result register;
// the glyph table read is registered at the accept edge, the cursor/box update of stage 1
// runs from that read data, and an end-of-text item's box goes to the result register.
// Reset: arst_n clears the cursor, origin and box to zero, sets the registers to their
// defaults and empties both stages; the glyph table holds garbage until loaded.
`default_nettype none
module text_bounding_box #(
	parameter int GLYPH_COUNT = tbb_pkg::GLYPH_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tbb_text_if.sink                           text,
	tbb_bbox_if.source                         bbox,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tbb_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [tbb_pkg::APB_DATA_W-1:0] pwdata,
	output      logic [tbb_pkg::APB_DATA_W-1:0] prdata,
	output      logic                          pready
);
	import tbb_pkg::*;

	localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
	localparam logic [8:0] COUNT_W9 = 9'(GLYPH_COUNT);

	cfg_t   cfg;
	glyph_t glyph_wr;
	glyph_t glyph_rd;
	box_t   box_next;

	logic       accept;
	logic       is_load;
	logic       is_begin;
	logic       is_char;
	logic       load_ok;
	logic       glyph_hit;
	logic [7:0] gi8;
	logic [7:0] rel_code;
	cmd_t       cmd_d;

	logic       valid_s1;
	cmd_t       cmd_s1;
	logic       step_s1;
	logic       out_busy;

	tbb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Decode the incoming item
	assign accept = text.valid && text.ready;
	assign is_load = (text.func == FUNC_LOAD);
	assign is_begin = (text.func == FUNC_BEGIN);
	assign is_char = (text.func == FUNC_CHAR);
	assign gi8 = {1'b0, text.glyph_index};
	assign load_ok = is_load && ({1'b0, gi8} < COUNT_W9);
	assign rel_code = text.char_code - cfg.first_char;
	// a printable code must sit in first..last and inside the table
	assign glyph_hit = (text.char_code != CODE_NEWLINE) && (text.char_code != CODE_CR)
		&& (text.char_code >= cfg.first_char) && (text.char_code <= cfg.last_char)
		&& ({1'b0, rel_code} < COUNT_W9);

	always_comb begin
		cmd_d.emit = text.end_of_text;
		cmd_d.origin_x = text.origin_x;
		cmd_d.origin_y = text.origin_y;
		if (is_begin) begin
			cmd_d.op = OP_BEGIN;
		end else if (text.char_code == CODE_NEWLINE) begin
			cmd_d.op = OP_NEWLINE;
		end else if (glyph_hit) begin
			cmd_d.op = OP_GLYPH;
		end else begin
			cmd_d.op = OP_SKIP;
		end
	end

	assign glyph_wr.w = text.glyph_width;
	assign glyph_wr.h = text.glyph_height;
	assign glyph_wr.xo = text.offset_x;
	assign glyph_wr.yo = text.offset_y;
	assign glyph_wr.xa = text.advance_x;

	// Write on an accepted load; read at the accept edge so data is ready in stage 1
	tbb_glyph_table #(
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_table (
		.clk     (clk),
		.wr_en   (accept && load_ok),
		.wr_addr (gi8[IDX_W-1:0]),
		.wr_data (glyph_wr),
		.rd_en   (accept && is_char && glyph_hit),
		.rd_addr (rel_code[IDX_W-1:0]),
		.rd_data (glyph_rd)
	);

	// Stage 1 holds a begin or character command; loads stop here, reserved codes pass as skips.
	// Advance unless it carries a result and the result register is still held.
	assign step_s1 = valid_s1 && !(cmd_s1.emit && out_busy);
	assign text.ready = !valid_s1 || step_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= accept && (is_begin || is_char);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

	tbb_cursor u_cursor (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step_s1),
		.cmd          (cmd_s1),
		.glyph        (glyph_rd),
		.line_advance (cfg.line_advance),
		.box_next     (box_next)
	);

	// Capture the updated box when the last item of the text leaves stage 1
	tbb_result u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step_s1 && cmd_s1.emit),
		.box    (box_next),
		.busy   (out_busy),
		.bbox   (bbox)
	);
endmodule
`default_nettype wire
